// ===== src/sorted_insert_priority_queue_defines.svh =====
// Assertion macros shared by the queue's checker.
`ifndef SORTED_INSERT_PRIORITY_QUEUE_DEFINES_SVH
`define SORTED_INSERT_PRIORITY_QUEUE_DEFINES_SVH

// Clocked assertion, disabled while reset is high.
`define SIPQ_ASSERT_CLK(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Same, on the checker's own clock and reset.
`define SIPQ_ASSERT(label, prop, msg) \
   `SIPQ_ASSERT_CLK(label, clock, reset, prop, msg)

`endif

// ===== src/sipq_pkg.sv =====
// Types and constants of the sorted-insert priority queue.
`default_nettype none
package sipq_pkg;

   localparam int DEFAULT_QUEUE_DEPTH = 32;
   localparam int VALUE_W             = 8;
   localparam int PRIO_W              = 3;
   localparam int STATUS_W            = 2;
   localparam int OCC_W               = 6;
   localparam int REQ_TDATA_W         = 16;
   localparam int RSP_TDATA_W         = 24;

   localparam logic CMD_PUSH = 1'b0;
   localparam logic CMD_POP  = 1'b1;

   localparam logic [STATUS_W-1:0] STATUS_DONE  = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_EMPTY = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd2;

   typedef struct packed {
      logic [VALUE_W-1:0] value;
      logic [PRIO_W-1:0]  prio;
   } entry_type;

   // Broadcast to every cell for one beat.
   typedef struct packed {
      logic      push;
      logic      pop;
      entry_type item;
   } ctrl_type;

endpackage
`default_nettype wire

// ===== src/sipq_cell.sv =====
// One slot of the sorted chain: holds an entry and shifts with its neighbors.
`default_nettype none
module sipq_cell (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire sipq_pkg::ctrl_type ctrl,
   input  wire sipq_pkg::entry_type left_entry,
   input  wire logic              left_valid,
   input  wire logic              left_ahead,
   input  wire sipq_pkg::entry_type right_entry,
   input  wire logic              right_valid,
   output sipq_pkg::entry_type    entry,
   output logic                   valid,
   output logic                   ahead
);

   sipq_pkg::entry_type entry_ff, entry_in;
   logic                valid_ff, valid_in;

   // New item belongs in front of this slot (an empty slot counts as behind it).
   always_comb begin
      ahead = !valid_ff
           || (ctrl.item.prio > entry_ff.prio)
           || ((ctrl.item.prio == entry_ff.prio)
               && (ctrl.item.value <= entry_ff.value));
   end

   always_comb begin
      entry_in = entry_ff;
      valid_in = valid_ff;
      if (ctrl.pop) begin
         entry_in = right_entry;
         valid_in = right_valid;
      end else if (ctrl.push) begin
         valid_in = valid_ff || left_valid;
         if (ahead) begin
            entry_in = left_ahead ? left_entry : ctrl.item;
         end
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   assign entry = entry_ff;
   assign valid = valid_ff;

endmodule
`default_nettype wire

// ===== src/sorted_insert_priority_queue.sv =====
// Top level: sorted priority queue built as a shifting chain of slots.
// The result of a beat appears on rsp in the cycle after it is accepted.
// One push or pop per cycle when ready; every slot compares and shifts in parallel.
// A result waiting on rsp does not block req while rsp_tready is high.
// Synchronous reset empties the queue; slot contents are left as they are.
`default_nettype none
module sorted_insert_priority_queue #(
   parameter int QUEUE_DEPTH = sipq_pkg::DEFAULT_QUEUE_DEPTH
) (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             req_tvalid,
   output logic                                  req_tready,
   // [7:0] item_value, [10:8] item_priority, [15:11] zero
   input  wire logic [sipq_pkg::REQ_TDATA_W-1:0] req_tdata,
   // [0] cmd
   input  wire logic                             req_tuser,
   output logic                                  rsp_tvalid,
   input  wire logic                             rsp_tready,
   // [7:0] popped_value, [10:8] popped_priority, [16:11] occupancy, [23:17] zero
   output logic [sipq_pkg::RSP_TDATA_W-1:0]      rsp_tdata,
   // [1:0] status
   output logic [sipq_pkg::STATUS_W-1:0]         rsp_tuser
);

   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   sipq_pkg::ctrl_type  ctrl;
   sipq_pkg::entry_type cell_entry [QUEUE_DEPTH];
   logic [QUEUE_DEPTH-1:0] cell_valid;
   logic [QUEUE_DEPTH-1:0] cell_ahead;

   logic                   accept, is_pop, empty, full;
   logic [CNT_W-1:0]       count_ff, count_in;
   logic [CNT_W+sipq_pkg::OCC_W-1:0] count_ext;

   logic                            rsp_valid_ff, rsp_valid_in;
   sipq_pkg::entry_type             rsp_entry_ff, rsp_entry_in;
   logic [sipq_pkg::STATUS_W-1:0]   rsp_status_ff, rsp_status_in;
   logic [sipq_pkg::OCC_W-1:0]      rsp_occ_ff, rsp_occ_in;

   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign accept     = req_tvalid && req_tready;
   assign is_pop     = (req_tuser == sipq_pkg::CMD_POP);
   assign empty      = !cell_valid[0];
   assign full       = cell_valid[QUEUE_DEPTH-1];

   always_comb begin
      ctrl.push       = accept && !is_pop && !full;
      ctrl.pop        = accept && is_pop && !empty;
      ctrl.item.value = req_tdata[sipq_pkg::VALUE_W-1:0];
      ctrl.item.prio  = req_tdata[sipq_pkg::VALUE_W +: sipq_pkg::PRIO_W];
   end

   for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
      sipq_pkg::entry_type left_entry, right_entry;
      logic                left_valid, left_ahead, right_valid;
      if (i == 0) begin : g_head
         assign left_entry = '0;
         assign left_valid = 1'b1;
         assign left_ahead = 1'b0;
      end else begin : g_mid
         assign left_entry = cell_entry[i-1];
         assign left_valid = cell_valid[i-1];
         assign left_ahead = cell_ahead[i-1];
      end
      if (i == QUEUE_DEPTH - 1) begin : g_tail
         assign right_entry = '0;
         assign right_valid = 1'b0;
      end else begin : g_body
         assign right_entry = cell_entry[i+1];
         assign right_valid = cell_valid[i+1];
      end
      sipq_cell u_cell (
         .clock       (clock),
         .reset       (reset),
         .ctrl        (ctrl),
         .left_entry  (left_entry),
         .left_valid  (left_valid),
         .left_ahead  (left_ahead),
         .right_entry (right_entry),
         .right_valid (right_valid),
         .entry       (cell_entry[i]),
         .valid       (cell_valid[i]),
         .ahead       (cell_ahead[i])
      );
   end

   always_comb begin
      count_in = count_ff;
      if (ctrl.push) begin
         count_in = count_ff + CNT_W'(1);
      end else if (ctrl.pop) begin
         count_in = count_ff - CNT_W'(1);
      end
      count_ext = {{sipq_pkg::OCC_W{1'b0}}, count_in};
   end

   always_comb begin
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      rsp_entry_in  = rsp_entry_ff;
      rsp_status_in = rsp_status_ff;
      rsp_occ_in    = rsp_occ_ff;
      if (accept) begin
         rsp_valid_in  = 1'b1;
         rsp_entry_in  = ctrl.pop ? cell_entry[0] : '0;
         rsp_occ_in    = count_ext[sipq_pkg::OCC_W-1:0];
         rsp_status_in = sipq_pkg::STATUS_DONE;
         if (is_pop && empty) begin
            rsp_status_in = sipq_pkg::STATUS_EMPTY;
         end else if (!is_pop && full) begin
            rsp_status_in = sipq_pkg::STATUS_FULL;
         end
      end
   end

   always_ff @(posedge clock) begin
      rsp_entry_ff  <= rsp_entry_in;
      rsp_status_ff <= rsp_status_in;
      rsp_occ_ff    <= rsp_occ_in;
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         count_ff     <= '0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         count_ff     <= count_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_status_ff;
   assign rsp_tdata  = {
      {(sipq_pkg::RSP_TDATA_W - sipq_pkg::OCC_W - sipq_pkg::PRIO_W
        - sipq_pkg::VALUE_W){1'b0}},
      rsp_occ_ff, rsp_entry_ff.prio, rsp_entry_ff.value
   };

endmodule
`default_nettype wire

// ===== src/sipq_checker.sv =====
// Port-level checks for the sorted-insert priority queue, bound to the top level.
`default_nettype none
`include "sorted_insert_priority_queue_defines.svh"
module sipq_checker #(
   parameter int QUEUE_DEPTH = sipq_pkg::DEFAULT_QUEUE_DEPTH
) (
   input wire logic                             clock,
   input wire logic                             reset,
   input wire logic                             req_tvalid,
   input wire logic                             req_tready,
   input wire logic                             rsp_tvalid,
   input wire logic                             rsp_tready,
   input wire logic [sipq_pkg::RSP_TDATA_W-1:0] rsp_tdata,
   input wire logic [sipq_pkg::STATUS_W-1:0]    rsp_tuser
);

   localparam int OCC_LSB = sipq_pkg::VALUE_W + sipq_pkg::PRIO_W;
   localparam logic [sipq_pkg::OCC_W-1:0] FULL_OCC = sipq_pkg::OCC_W'(QUEUE_DEPTH);

   logic req_beat;
   assign req_beat = req_tvalid && req_tready;

   // a stalled result holds
   `SIPQ_ASSERT(a_rsp_hold,
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser),
      "rsp beat changed while stalled")

   // every accepted request yields a result on the next cycle
   `SIPQ_ASSERT(a_rsp_follows,
      req_beat |=> rsp_tvalid,
      "no result after accepted request")

   // pop on empty reports an empty queue and no entry
   `SIPQ_ASSERT(a_empty_result,
      rsp_tvalid && rsp_tuser == sipq_pkg::STATUS_EMPTY |->
         rsp_tdata[OCC_LSB +: sipq_pkg::OCC_W] == '0 && rsp_tdata[OCC_LSB-1:0] == '0,
      "empty status with nonzero payload")

   // dropped push leaves the queue full
   `SIPQ_ASSERT(a_full_result,
      rsp_tvalid && rsp_tuser == sipq_pkg::STATUS_FULL |->
         rsp_tdata[OCC_LSB +: sipq_pkg::OCC_W] == FULL_OCC,
      "full status with wrong occupancy")

endmodule

bind sorted_insert_priority_queue sipq_checker #(
   .QUEUE_DEPTH (QUEUE_DEPTH)
) u_sipq_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);
`default_nettype wire

// ===== test/tb_sorted_insert_priority_queue.sv =====
// Testbench for the sorted-insert priority queue: directed and random push/pop traffic vs. a software list.
`default_nettype none
module tb_sorted_insert_priority_queue;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int DEPTH       = sipq_pkg::DEFAULT_QUEUE_DEPTH;
   localparam int N_ITEMS     = 1850;
   localparam int MAX_GAP     = 12;
   localparam int LONG_HOLD   = 300;
   localparam int CYCLE_LIMIT = 500000;
   localparam int REPORT_MAX  = 10;
   localparam int TAIL_CYCLES = 8;
   localparam int VAL_W       = sipq_pkg::VALUE_W;
   localparam int PRI_W       = sipq_pkg::PRIO_W;
   localparam int ST_W        = sipq_pkg::STATUS_W;
   localparam int OCC_W       = sipq_pkg::OCC_W;
   localparam int REQ_W       = sipq_pkg::REQ_TDATA_W;
   localparam int RSP_W       = sipq_pkg::RSP_TDATA_W;
   localparam int OCC_LSB     = VAL_W + PRI_W;
   localparam int PAD_LSB     = OCC_LSB + OCC_W;
   localparam int PAD_W       = RSP_W - PAD_LSB;

   typedef struct packed {
      logic             cmd;
      logic [VAL_W-1:0] val;
      logic [PRI_W-1:0] prio;
   } op_type;

   typedef struct packed {
      logic [VAL_W-1:0] val;
      logic [PRI_W-1:0] prio;
      logic [ST_W-1:0]  status;
      logic [OCC_W-1:0] occ;
      logic [PAD_W-1:0] pad;
   } outcome_type;

   logic             clock      = 1'b0;
   logic             reset      = 1'b1;
   logic             req_tvalid = 1'b0;
   logic             req_tready;
   logic [REQ_W-1:0] req_tdata  = '0;
   logic             req_tuser  = sipq_pkg::CMD_PUSH;
   logic             rsp_tvalid;
   logic             rsp_tready = 1'b0;
   logic [RSP_W-1:0] rsp_tdata;
   logic [ST_W-1:0]  rsp_tuser;

   sorted_insert_priority_queue #(.QUEUE_DEPTH(DEPTH)) dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   always #1 clock = ~clock;

   op_type      pending_ops[$];
   outcome_type expected_outcomes[$];

   // software copy of the sorted list, head at index 0
   logic [VAL_W-1:0] sorted_val  [DEPTH];
   logic [PRI_W-1:0] sorted_prio [DEPTH];
   int               held = 0;

   bit req_taken = 1'b0;
   bit rsp_taken = 1'b0;
   bit req_idle  = 1'b1;
   bit rsp_idle  = 1'b1;
   bit rsp_hold  = 1'b0;
   int req_wait  = 0;
   int rsp_wait  = 0;

   int errors      = 0;
   int beats_in    = 0;
   int beats_out   = 0;
   int n_push      = 0;
   int n_pop       = 0;
   int n_empty     = 0;
   int n_full      = 0;
   int peak_held   = 0;
   int req_stalls  = 0;
   int cycle_count = 0;

   function automatic outcome_type queue_apply(op_type op);
      outcome_type r;
      int          pos;
      r = '0;
      if (op.cmd == sipq_pkg::CMD_POP) begin
         if (held == 0) begin
            r.status = sipq_pkg::STATUS_EMPTY;
         end else begin
            r.val  = sorted_val[0];
            r.prio = sorted_prio[0];
            for (int i = 1; i < held; i++) begin
               sorted_val[i-1]  = sorted_val[i];
               sorted_prio[i-1] = sorted_prio[i];
            end
            held--;
            r.status = sipq_pkg::STATUS_DONE;
         end
      end else if (held >= DEPTH) begin
         r.status = sipq_pkg::STATUS_FULL;
      end else begin
         // higher priority first, then smaller value; a tie goes ahead of held entries
         pos = 0;
         while (pos < held && sorted_prio[pos] > op.prio) pos++;
         while (pos < held && sorted_prio[pos] == op.prio && sorted_val[pos] < op.val) pos++;
         for (int i = held; i > pos; i--) begin
            sorted_val[i]  = sorted_val[i-1];
            sorted_prio[i] = sorted_prio[i-1];
         end
         sorted_val[pos]  = op.val;
         sorted_prio[pos] = op.prio;
         held++;
         r.status = sipq_pkg::STATUS_DONE;
      end
      r.occ = held[OCC_W-1:0];
      return r;
   endfunction

   function automatic void report_mismatch(string what, outcome_type want,
                                           outcome_type got);
      errors++;
      if (errors <= REPORT_MAX)
         $display("%t %s: want val %0d prio %0d status %0d occ %0d pad %0h", $realtime, what,
                  want.val, want.prio, want.status, want.occ, want.pad,
                  " | got val %0d prio %0d status %0d occ %0d pad %0h",
                  got.val, got.prio, got.status, got.occ, got.pad);
   endfunction

   // monitor and checker
   always @(posedge clock) begin
      outcome_type want;
      outcome_type got;
      op_type      op;
      if (!reset) begin
         req_taken = req_tvalid && req_tready;
         rsp_taken = rsp_tvalid && rsp_tready;
         if (req_tvalid && !req_tready) req_stalls++;
         // a result always belongs to an earlier beat, so check it before predicting
         if (rsp_taken) begin
            beats_out++;
            got.val    = rsp_tdata[VAL_W-1:0];
            got.prio   = rsp_tdata[OCC_LSB-1:VAL_W];
            got.occ    = rsp_tdata[PAD_LSB-1:OCC_LSB];
            got.pad    = rsp_tdata[RSP_W-1:PAD_LSB];
            got.status = rsp_tuser;
            if (expected_outcomes.size() == 0) begin
               report_mismatch("unexpected result", '0, got);
            end else begin
               want = expected_outcomes.pop_front();
               if (got !== want) report_mismatch("mismatch", want, got);
            end
         end
         if (req_taken) begin
            beats_in++;
            op.cmd  = req_tuser;
            op.val  = req_tdata[VAL_W-1:0];
            op.prio = req_tdata[OCC_LSB-1:VAL_W];
            want = queue_apply(op);
            expected_outcomes.push_back(want);
            if (want.status == sipq_pkg::STATUS_EMPTY) n_empty++;
            else if (want.status == sipq_pkg::STATUS_FULL) n_full++;
            else if (op.cmd == sipq_pkg::CMD_POP) n_pop++;
            else n_push++;
            if (held > peak_held) peak_held = held;
         end
      end
   end

   // request driver
   always @(negedge clock) begin
      op_type op;
      if (reset) begin
         req_tvalid <= 1'b0;
      end else if (!req_tvalid || req_taken) begin
         if (req_wait > 0) begin
            req_wait--;
            req_tvalid <= 1'b0;
         end else if (pending_ops.size() > 0) begin
            op = pending_ops.pop_front();
            req_tvalid <= 1'b1;
            req_tuser  <= op.cmd;
            req_tdata  <= {{(REQ_W-VAL_W-PRI_W){1'b0}}, op.prio, op.val};
            if ($urandom_range(0, 99) == 0) req_idle = !req_idle;
            req_wait = req_idle ? $urandom_range(0, MAX_GAP) : 0;
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   // result receiver
   always @(negedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_taken) begin
            if ($urandom_range(0, 99) == 0) rsp_idle = !rsp_idle;
            rsp_wait = rsp_idle ? $urandom_range(0, MAX_GAP) : 0;
         end
         if (rsp_hold) begin
            rsp_tready <= 1'b0;
         end else if (rsp_wait > 0) begin
            rsp_wait--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   // long back-pressure: the output register stays full and req_tready drops
   initial begin
      for (int k = 1; k <= 2; k++) begin
         wait (beats_in >= k * 600);
         rsp_hold = 1'b1;
         repeat (LONG_HOLD) @(posedge clock);
         rsp_hold = 1'b0;
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d results outstanding",
                  CYCLE_LIMIT, expected_outcomes.size());
         $display("status: fail");
         $finish;
      end
   end

   function automatic void add_op(logic cmd, int val, int prio);
      op_type op;
      op.cmd  = cmd;
      op.val  = val[VAL_W-1:0];
      op.prio = prio[PRI_W-1:0];
      pending_ops.push_back(op);
   endfunction

   initial begin
      int queued;
      int mode;
      int span;
      int push_pct;
      bit narrow;

      // directed: empty pop, field extremes, priority and value ordering, exact ties
      add_op(sipq_pkg::CMD_POP, 0, 0);
      add_op(sipq_pkg::CMD_PUSH, 255, 7);
      add_op(sipq_pkg::CMD_PUSH, 0, 0);
      add_op(sipq_pkg::CMD_PUSH, 0, 7);
      add_op(sipq_pkg::CMD_PUSH, 255, 0);
      add_op(sipq_pkg::CMD_PUSH, 128, 3);
      add_op(sipq_pkg::CMD_PUSH, 128, 3);
      add_op(sipq_pkg::CMD_PUSH, 127, 3);
      add_op(sipq_pkg::CMD_PUSH, 129, 3);
      add_op(sipq_pkg::CMD_PUSH, 85, 5);
      add_op(sipq_pkg::CMD_PUSH, 170, 2);
      add_op(sipq_pkg::CMD_POP, 255, 7);
      repeat (10) add_op(sipq_pkg::CMD_POP, 0, 0);
      queued = pending_ops.size();

      // random phases: filling runs push toward full, draining runs toward empty, mixed runs in between
      while (queued < N_ITEMS) begin
         mode   = $urandom_range(0, 3);
         span   = $urandom_range(20, 80);
         narrow = (mode == 3) || ($urandom_range(0, 3) == 0);
         case (mode)
            0: push_pct = 85;
            1: push_pct = 15;
            2: push_pct = 50;
            default: push_pct = 60;
         endcase
         for (int i = 0; i < span && queued < N_ITEMS; i++) begin
            if ($urandom_range(0, 99) < push_pct)
               add_op(sipq_pkg::CMD_PUSH,
                      narrow ? $urandom_range(0, 3) : $urandom_range(0, 255),
                      narrow ? $urandom_range(0, 1) : $urandom_range(0, 7));
            else
               add_op(sipq_pkg::CMD_POP, $urandom_range(0, 255), $urandom_range(0, 7));
            queued++;
         end
      end

      repeat (5) @(posedge clock);
      @(negedge clock) reset <= 1'b0;

      while (pending_ops.size() > 0 || req_tvalid || expected_outcomes.size() > 0)
         @(negedge clock);
      repeat (TAIL_CYCLES) @(negedge clock);

      if (expected_outcomes.size() > 0) begin
         errors += expected_outcomes.size();
         $display("%0d results never arrived", expected_outcomes.size());
      end

      $display("ran %0d beats in, %0d out: %0d inserts, %0d removals, peak depth %0d",
               beats_in, beats_out, n_push, n_pop, peak_held);
      $display("pops on empty %0d, pushes dropped when full %0d, input stall cycles %0d",
               n_empty, n_full, req_stalls);
      if (errors == 0) begin
         $display("status: pass");
      end else begin
         $display("%0d errors", errors);
         $display("status: fail");
      end
      $finish;
   end

endmodule
`default_nettype wire
